/* sv/first_fit_block_allocator_core_assert.svh */
// assertion macros for the first-fit allocator core
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// clocked check, masked while reset is asserted
`define FFBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that must hold during reset as well
`define FFBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/ffba_pkg.sv */
// shared types and constants for the first-fit allocator
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int PADDR_W     = 2;

  localparam logic [31:0]        HEAP_BASE_RESET = 32'h8400_0000;
  localparam logic [PADDR_W-1:0] REG_HEAP_BASE   = PADDR_W'(0);

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [31:0] request_size;
    logic [31:0] block_address;
  } in_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_INSERT,
    S_DONE
  } state_t;

endpackage

/* sv/first_fit_block_allocator_core.sv */
// first-fit allocator: block table in one memory, scanned and shifted in place
`timescale 1ns / 1ps

// Input channel in_valid/in_stall/in_data carries one request transaction:
// mode 0 allocates request_size bytes, mode 1 frees the block at block_address.
// Every request gives exactly one transaction on out_valid/out_stall/out_data
// with the allocated start (zero on failure or free) and a status code.
// heap_base is written over the APB port (byte address 0); the user must write
// it only while idle, as the block itself does not enforce this. One request
// is worked at a time; in_stall is high from acceptance until the result is
// moved into the output register. The block table sits in a single memory
// with one read and one write per cycle, so the scan reads one entry a cycle.
// An allocate scans the table, shifts any later entries up and then inserts;
// a free scans and shifts any later entries down; an allocate on a full table
// goes straight to the result. in_stall falls in the same cycle as out_valid
// rises. A stalled result waits in the output register and the next request
// may be accepted meanwhile; a finished request is held until that register
// frees. Synchronous reset empties the table (count cleared, no memory pass)
// and sets heap_base to 0x84000000.
module first_fit_block_allocator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ffba_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ffba_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffba_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int IDX_W = ffba_pkg::IDX_W;
  localparam int CNT_W = ffba_pkg::CNT_W;

  ffba_pkg::entry_t mem [ffba_pkg::TABLE_DEPTH];
  ffba_pkg::entry_t mem_q;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;
  ffba_pkg::entry_t wr_data;

  ffba_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [31:0]      heap_base_r;
  logic             out_valid_r, out_valid_nxt;
  ffba_pkg::out_t   out_data_r, out_data_nxt;

  logic             mode_r, mode_nxt;
  logic [31:0]      size_r, size_nxt;
  logic [31:0]      addr_r, addr_nxt;
  logic [31:0]      run_r, run_nxt;
  logic [CNT_W-1:0] s_r, s_nxt;
  logic             v_r, v_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] rr_r, rr_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [IDX_W-1:0] sh_wr_r, sh_wr_nxt;
  logic             sv_r, sv_nxt;
  ffba_pkg::out_t   res_r, res_nxt;

  logic        in_acc;
  logic        is_alloc;
  logic        table_full;
  logic        gap_ok;
  logic        hit;
  logic        more;
  logic [31:0] run_eff;
  logic        out_free;
  logic        cfg_wr;
  logic        tbl_update;
  logic        in_insert;

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  assign in_stall   = (state_r != ffba_pkg::S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign is_alloc   = (mode_r == ffba_pkg::MODE_ALLOC);
  assign table_full = (used_r == CNT_W'(ffba_pkg::TABLE_DEPTH));
  assign gap_ok     = (mem_q.start >= run_r) && ((mem_q.start - run_r) >= size_r);
  assign hit        = v_r && (is_alloc ? gap_ok : (mem_q.start == addr_r));
  assign more       = (s_r < used_r);
  assign run_eff    = v_r ? (mem_q.start + mem_q.length) : run_r;
  assign out_free   = !out_valid_r || !out_stall;

  assign tbl_update = (state_r == ffba_pkg::S_SHIFT_UP) ||
                      (state_r == ffba_pkg::S_SHIFT_DN) ||
                      (state_r == ffba_pkg::S_INSERT);
  assign in_insert  = (state_r == ffba_pkg::S_INSERT);

  assign cfg_wr = psel && penable && pwrite && (paddr == ffba_pkg::REG_HEAP_BASE);
  assign pready = 1'b1;
  assign prdata = (paddr == ffba_pkg::REG_HEAP_BASE) ? heap_base_r : 32'd0;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffba_pkg::S_IDLE: begin
        if (in_acc) begin
          if ((in_data.mode == ffba_pkg::MODE_ALLOC) && table_full) begin
            state_nxt = ffba_pkg::S_DONE;
          end else begin
            state_nxt = ffba_pkg::S_SCAN;
          end
        end
      end
      ffba_pkg::S_SCAN: begin
        if (hit) begin
          state_nxt = is_alloc ? ffba_pkg::S_SHIFT_UP : ffba_pkg::S_SHIFT_DN;
        end else if (!more) begin
          state_nxt = is_alloc ? ffba_pkg::S_INSERT : ffba_pkg::S_DONE;
        end
      end
      ffba_pkg::S_SHIFT_UP: begin
        if (left_r == '0) state_nxt = ffba_pkg::S_INSERT;
      end
      ffba_pkg::S_SHIFT_DN: begin
        if (left_r == '0) state_nxt = ffba_pkg::S_DONE;
      end
      ffba_pkg::S_INSERT: state_nxt = ffba_pkg::S_DONE;
      ffba_pkg::S_DONE: begin
        if (out_free) state_nxt = ffba_pkg::S_IDLE;
      end
      default: state_nxt = ffba_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    used_nxt      = used_r;
    mode_nxt      = mode_r;
    size_nxt      = size_r;
    addr_nxt      = addr_r;
    run_nxt       = run_r;
    s_nxt         = s_r;
    v_nxt         = v_r;
    pos_nxt       = pos_r;
    rr_nxt        = rr_r;
    left_nxt      = left_r;
    sh_wr_nxt     = sh_wr_r;
    sv_nxt        = sv_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    rd_addr       = s_r[IDX_W-1:0];
    mem_we        = 1'b0;
    wr_addr       = sh_wr_r;
    wr_data       = mem_q;

    unique case (state_r)
      ffba_pkg::S_IDLE: begin
        if (in_acc) begin
          mode_nxt = in_data.mode;
          size_nxt = in_data.request_size;
          addr_nxt = in_data.block_address;
          run_nxt  = heap_base_r;
          s_nxt    = '0;
          v_nxt    = 1'b0;
          res_nxt  = '{result_address: 32'd0, status: ffba_pkg::ST_FULL};
        end
      end
      ffba_pkg::S_SCAN: begin
        if (hit) begin
          pos_nxt = s_r - CNT_W'(1);
          sv_nxt  = 1'b0;
          if (is_alloc) begin
            rr_nxt   = used_r - CNT_W'(1);
            left_nxt = used_r - s_r + CNT_W'(1);
          end else begin
            rr_nxt   = s_r;
            left_nxt = used_r - s_r;
          end
        end else begin
          if (is_alloc) run_nxt = run_eff;
          if (more) begin
            s_nxt = s_r + CNT_W'(1);
            v_nxt = 1'b1;
          end else begin
            pos_nxt = used_r;
            res_nxt = '{result_address: 32'd0, status: ffba_pkg::ST_NOT_FOUND};
          end
        end
      end
      ffba_pkg::S_SHIFT_UP: begin
        // read entry rr, then write the registered entry one slot up
        rd_addr = rr_r[IDX_W-1:0];
        mem_we  = sv_r;
        if (left_r != '0) begin
          sh_wr_nxt = IDX_W'(rr_r + CNT_W'(1));
          rr_nxt    = rr_r - CNT_W'(1);
          left_nxt  = left_r - CNT_W'(1);
          sv_nxt    = 1'b1;
        end else begin
          sv_nxt = 1'b0;
        end
      end
      ffba_pkg::S_SHIFT_DN: begin
        // read entry rr, then write the registered entry one slot down
        rd_addr = rr_r[IDX_W-1:0];
        mem_we  = sv_r;
        if (left_r != '0) begin
          sh_wr_nxt = IDX_W'(rr_r - CNT_W'(1));
          rr_nxt    = rr_r + CNT_W'(1);
          left_nxt  = left_r - CNT_W'(1);
          sv_nxt    = 1'b1;
        end else begin
          sv_nxt   = 1'b0;
          used_nxt = used_r - CNT_W'(1);
          res_nxt  = '{result_address: 32'd0, status: ffba_pkg::ST_OK};
        end
      end
      ffba_pkg::S_INSERT: begin
        mem_we   = 1'b1;
        wr_addr  = pos_r[IDX_W-1:0];
        wr_data  = '{start: run_r, length: size_r};
        used_nxt = used_r + CNT_W'(1);
        res_nxt  = '{result_address: run_r, status: ffba_pkg::ST_OK};
      end
      ffba_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffba_pkg::S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      heap_base_r <= ffba_pkg::HEAP_BASE_RESET;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) heap_base_r <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    size_r     <= size_nxt;
    addr_r     <= addr_nxt;
    run_r      <= run_nxt;
    s_r        <= s_nxt;
    v_r        <= v_nxt;
    pos_r      <= pos_nxt;
    rr_r       <= rr_nxt;
    left_r     <= left_nxt;
    sh_wr_r    <= sh_wr_nxt;
    sv_r       <= sv_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

`include "first_fit_block_allocator_core_assert.svh"

  `FFBA_ASSERT(a_used_bound, used_r <= CNT_W'(ffba_pkg::TABLE_DEPTH), "entry count past depth")
  `FFBA_ASSERT(a_accept_busy, in_acc |=> in_stall, "accept left block idle")
  `FFBA_ASSERT(a_write_state, mem_we |-> tbl_update, "table written outside update")
  `FFBA_ASSERT(a_insert_count, in_insert |=> (used_r == $past(used_r) + CNT_W'(1)), "no count bump")

endmodule

/* bench/tb_first_fit_block_allocator_core.sv */
// self-checking testbench for the first-fit block allocator core
`timescale 1ns / 1ps

module tb_first_fit_block_allocator_core;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned IDLE_PCT    = 9;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  ffba_pkg::in_t                in_data   = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  ffba_pkg::out_t               out_data;
  logic                         psel      = 1'b0;
  logic                         penable   = 1'b0;
  logic                         pwrite    = 1'b0;
  logic [ffba_pkg::PADDR_W-1:0] paddr     = '0;
  logic [31:0]                  pwdata    = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  // shadow copy of the block table and heap base
  logic [31:0] shadow_start [ffba_pkg::TABLE_DEPTH];
  logic [31:0] shadow_len [ffba_pkg::TABLE_DEPTH];
  int unsigned shadow_used      = 0;
  logic [31:0] shadow_heap_base = ffba_pkg::HEAP_BASE_RESET;

  ffba_pkg::out_t awaited_replies[$];
  int unsigned    mismatches = 0;
  int unsigned    cycles     = 0;
  bit             quiet      = 1'b0;

  first_fit_block_allocator_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding",
               $time, awaited_replies.size());
      $display("Verification failed");
      $finish;
    end
  end

  // first-fit placement and removal on the shadow table
  function automatic ffba_pkg::out_t first_fit_apply(input ffba_pkg::in_t req);
    ffba_pkg::out_t rsp;
    logic [31:0]    run;
    int unsigned    pos;
    int unsigned    i;
    bit             hit;
    rsp = '0;
    hit = 1'b0;
    pos = shadow_used;
    if (req.mode == ffba_pkg::MODE_ALLOC) begin
      run = shadow_heap_base;
      for (i = 0; i < shadow_used && !hit; i++) begin
        if (shadow_start[i] >= run && shadow_start[i] - run >= req.request_size) begin
          hit = 1'b1;
          pos = i;
        end else begin
          run = shadow_start[i] + shadow_len[i];
        end
      end
      if (shadow_used >= ffba_pkg::TABLE_DEPTH) begin
        rsp.status = ffba_pkg::ST_FULL;
      end else begin
        for (i = shadow_used; i > pos; i--) begin
          shadow_start[i] = shadow_start[i-1];
          shadow_len[i]   = shadow_len[i-1];
        end
        shadow_start[pos]  = run;
        shadow_len[pos]    = req.request_size;
        shadow_used        = shadow_used + 1;
        rsp.result_address = run;
        rsp.status         = ffba_pkg::ST_OK;
      end
    end else begin
      rsp.status = ffba_pkg::ST_NOT_FOUND;
      // first matching entry wins
      for (i = 0; i < shadow_used && !hit; i++) begin
        if (shadow_start[i] == req.block_address) begin
          hit = 1'b1;
          pos = i;
        end
      end
      if (hit) begin
        for (i = pos; i + 1 < shadow_used; i++) begin
          shadow_start[i] = shadow_start[i+1];
          shadow_len[i]   = shadow_len[i+1];
        end
        shadow_used = shadow_used - 1;
        rsp.status  = ffba_pkg::ST_OK;
      end
    end
    return rsp;
  endfunction

  function automatic ffba_pkg::in_t alloc_req(input logic [31:0] size);
    ffba_pkg::in_t r;
    r.mode          = ffba_pkg::MODE_ALLOC;
    r.request_size  = size;
    r.block_address = $urandom;
    return r;
  endfunction

  function automatic ffba_pkg::in_t free_req(input logic [31:0] addr);
    ffba_pkg::in_t r;
    r.mode          = ffba_pkg::MODE_FREE;
    r.request_size  = $urandom;
    r.block_address = addr;
    return r;
  endfunction

  // mostly frees of live blocks and modest allocations, with some noise
  function automatic ffba_pkg::in_t random_request();
    int unsigned roll;
    int unsigned free_pct;
    free_pct = (shadow_used > 40) ? 75 : ((shadow_used < 8) ? 25 : 50);
    roll = $urandom_range(0, 99);
    if (roll < free_pct) begin
      if (shadow_used != 0 && $urandom_range(0, 9) != 0)
        return free_req(shadow_start[$urandom_range(0, shadow_used - 1)]);
      return free_req($urandom);
    end
    roll = $urandom_range(0, 99);
    if (roll < 6) return alloc_req(32'd0);
    if (roll < 9) return alloc_req($urandom);
    return alloc_req($urandom_range(1, 512));
  endfunction

  task automatic send_request(input ffba_pkg::in_t req);
    bit lowered;
    lowered = 1'b0;
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      if (!lowered) begin
        in_valid <= 1'b0;
        lowered = 1'b1;
      end
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    awaited_replies.push_back(first_fit_apply(req));
  endtask

  task automatic wait_replies_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_replies.size() != 0);
  endtask

  task automatic write_heap_base(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ffba_pkg::REG_HEAP_BASE;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_heap_base = value;
    @(posedge clk);
  endtask

  task automatic check_heap_base(input logic [31:0] want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ffba_pkg::REG_HEAP_BASE;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      $display("%0t: heap_base read expected %h got %h", $time, want, got);
      mismatches++;
    end
    @(posedge clk);
  endtask

  task automatic clear_table();
    while (shadow_used != 0) send_request(free_req(shadow_start[0]));
    wait_replies_drained();
  endtask

  // result channel: random stalls and in-order comparison of each transaction
  task automatic check_reply(input ffba_pkg::out_t got);
    ffba_pkg::out_t want;
    if (awaited_replies.size() == 0) begin
      $display("%0t: unexpected result, expected none got address %h status %0d",
               $time, got.result_address, got.status);
      mismatches++;
    end else begin
      want = awaited_replies.pop_front();
      if (got.result_address !== want.result_address) begin
        $display("%0t: result_address expected %h got %h",
                 $time, want.result_address, got.result_address);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_reply(out_data);
    out_stall <= rst_n && !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  task automatic test_register_access();
    check_heap_base(ffba_pkg::HEAP_BASE_RESET);
    write_heap_base(32'hFFFF_FFFF);
    check_heap_base(32'hFFFF_FFFF);
    write_heap_base(32'h0000_0000);
    check_heap_base(32'h0000_0000);
    write_heap_base(ffba_pkg::HEAP_BASE_RESET);
    check_heap_base(ffba_pkg::HEAP_BASE_RESET);
  endtask

  task automatic test_first_fit_cases();
    logic [31:0] b;
    b = ffba_pkg::HEAP_BASE_RESET;
    send_request(alloc_req(32'd0));
    // same start as the zero-length block ahead of it
    send_request(alloc_req(32'h100));
    send_request(free_req(b));
    send_request(free_req(b));
    send_request(free_req(b));
    send_request(alloc_req(32'h40));
    send_request(alloc_req(32'h80));
    send_request(alloc_req(32'h20));
    send_request(free_req(b + 32'h40));
    // exact fit into the hole
    send_request(alloc_req(32'h80));
    send_request(free_req(b + 32'h40));
    send_request(alloc_req(32'h81));
    send_request(alloc_req(32'h10));
    // huge block pushes the running address past the top
    send_request(alloc_req(32'hFFFF_FFFF));
    send_request(alloc_req(32'h10));
    send_request(free_req(32'hFFFF_FFFF));
    send_request(free_req(32'h0000_0000));
    clear_table();
  endtask

  task automatic test_wrapping_heap();
    write_heap_base(32'hFFFF_FFFF);
    send_request(alloc_req(32'd1));
    send_request(alloc_req(32'h10));
    send_request(alloc_req(32'd0));
    send_request(free_req(32'hFFFF_FFFF));
    clear_table();
    write_heap_base(32'h0000_0000);
    send_request(alloc_req(32'h8000_0000));
    send_request(alloc_req(32'h8000_0000));
    send_request(alloc_req(32'd4));
    clear_table();
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned n;
    for (phase = 0; phase < 4; phase++) begin
      wait_replies_drained();
      case (phase)
        0:       write_heap_base(32'h0000_0000);
        1:       write_heap_base(32'h7FFF_FF00);
        2:       write_heap_base($urandom);
        default: write_heap_base(ffba_pkg::HEAP_BASE_RESET);
      endcase
      // one phase runs with no gaps on either side
      quiet = (phase == 1);
      for (n = 0; n < 64; n++) begin
        if (phase == 2 && n == 32) wait_replies_drained();
        send_request(random_request());
      end
    end
    quiet = 1'b0;
    wait_replies_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_first_fit_cases();
    test_wrapping_heap();
    test_random_traffic();
    wait_replies_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && awaited_replies.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
